[rtl/bsb_pkg.sv]
// Shared constants for the bitmap stream blit unit.
package bsb_pkg;

  localparam int unsigned MAX_DIM = 4096;

  // Field widths
  localparam int unsigned ADDR_W  = 27;
  localparam int unsigned SW_W    = 13;
  localparam int unsigned COL_W   = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLUMN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW      = 2'd3;

  // Configuration reset values
  localparam logic [SW_W-1:0]  SCREEN_WIDTH_RST = 13'd640;
  localparam logic             CENTER_MODE_RST  = 1'b1;
  localparam logic [COL_W-1:0] LEFT_COLUMN_RST  = 12'd0;
  localparam logic [COL_W-1:0] TOP_ROW_RST      = 12'd0;

  // Header byte positions
  localparam logic [31:0] OFS_FIRST = 32'd10;
  localparam logic [31:0] OFS_LAST  = 32'd13;
  localparam logic [31:0] WID_FIRST = 32'd18;
  localparam logic [31:0] WID_LAST  = 32'd21;
  localparam logic [31:0] HGT_FIRST = 32'd22;
  localparam logic [31:0] HGT_LAST  = 32'd25;
  localparam logic [31:0] BPP_LO    = 32'd28;
  localparam logic [31:0] BPP_HI    = 32'd29;
  localparam logic [31:0] MIN_OFS   = 32'd30;

  localparam logic [CNT_W-1:0] CHAN_LIMIT = 13'd3;

endpackage

[rtl/bsb_in_if.sv]
// Input channel: one bitmap file byte per item.
interface bsb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first_byte;

  modport source (output valid, output file_byte, output first_byte, input ready);
  modport sink   (input valid, input file_byte, input first_byte, output ready);
endinterface

[rtl/bsb_out_if.sv]
// Result channel: one framebuffer byte write per item.
interface bsb_out_if
  import bsb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [7:0]        write_byte;
  logic              off_frame;

  modport source (output valid, output write_address, output write_byte,
                  output off_frame, input ready);
  modport sink   (input valid, input write_address, input write_byte,
                  input off_frame, output ready);
endinterface

[rtl/bitmap_stream_blit_unit.sv]
// Bitmap stream blit unit: header parser and framebuffer byte write generator.
//
// in_chan carries a bitmap file one byte per item; first_byte marks byte 0 of
// a new file and clears the parser. Header fields (data offset, width,
// height, bit count) are captured from their little-endian byte positions.
// Each pixel byte among the first three of a pixel produces one item on
// out_chan: a framebuffer byte address (4 bytes per pixel, rows flipped),
// the byte value and an off-frame flag. Other bytes produce no item.
// cfg_we/cfg_index/cfg_data write the placement registers; write them only
// while the unit is idle.
// An accepted byte is registered in the operand stage (parser and counters
// plus operand setup), then in the result stage (row*stride multiply and
// address add). Throughput is one byte per cycle while out_chan does not
// stall, set by the channel/column/row counter update. Reset (rst_n low,
// synchronous) restores the register defaults and clears the parser and
// pipeline. When out_chan stalls, the result is held and one more result
// may wait in the operand stage; input is then held off until a slot frees.
module bitmap_stream_blit_unit
  import bsb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  bsb_in_if.sink               in_chan,
  bsb_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // Configuration
  logic [SW_W-1:0]  screen_width_r;
  logic             center_mode_r;
  logic [COL_W-1:0] left_column_r;
  logic [COL_W-1:0] top_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r <= SCREEN_WIDTH_RST;
      center_mode_r  <= CENTER_MODE_RST;
      left_column_r  <= LEFT_COLUMN_RST;
      top_row_r      <= TOP_ROW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH: screen_width_r <= cfg_data;
        CFG_CENTER_MODE:  center_mode_r  <= cfg_data[0];
        CFG_LEFT_COLUMN:  left_column_r  <= cfg_data[COL_W-1:0];
        CFG_TOP_ROW:      top_row_r      <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Parser state
  logic [31:0]      byte_pos_r, byte_pos_nxt;
  logic [31:0]      data_ofs_r, data_ofs_nxt;
  logic [31:0]      img_w_r, img_w_nxt;
  logic [31:0]      img_h_r, img_h_nxt;
  logic [15:0]      bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0] chan_r, chan_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;

  // Operand stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_byte_r, s1_byte_nxt;
  logic [1:0]        s1_chan_r, s1_chan_nxt;
  logic [CNT_W-1:0]  s1_col_r, s1_col_nxt;
  logic signed [13:0] s1_left_r, s1_left_nxt;
  logic [CNT_W-1:0]  s1_row_r, s1_row_nxt;

  // Result stage
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [7:0]        out_byte_r;
  logic              out_off_r;

  logic adv_out, adv_s1, in_acc;

  assign adv_out = !out_valid_r || out_chan.ready;
  assign adv_s1  = !s1_valid_r || adv_out;
  assign in_acc  = in_chan.valid && adv_s1;
  assign in_chan.ready = adv_s1;

  // Parse and count
  logic [31:0]      pos, ofs_c, w_c, h_c;
  logic [15:0]      bits_c;
  logic [CNT_W-1:0] chan_c, col_c, row_c, chan_inc, col_inc;
  logic [1:0]       lane;
  logic [11:0]      bpp;
  logic             pixel;
  logic signed [14:0] sw_diff;

  always_comb begin
    if (in_chan.first_byte) begin
      pos    = '0;
      ofs_c  = '0;
      w_c    = '0;
      h_c    = '0;
      bits_c = '0;
      chan_c = '0;
      col_c  = '0;
      row_c  = '0;
    end else begin
      pos    = byte_pos_r;
      ofs_c  = data_ofs_r;
      w_c    = img_w_r;
      h_c    = img_h_r;
      bits_c = bit_cnt_r;
      chan_c = chan_r;
      col_c  = col_r;
      row_c  = row_r;
    end

    lane = pos[1:0] - 2'd2;   // (pos - 10) mod 4; also right for 18 and 22 bases
    data_ofs_nxt = ofs_c;
    img_w_nxt    = w_c;
    img_h_nxt    = h_c;
    bit_cnt_nxt  = bits_c;
    if (pos >= OFS_FIRST && pos <= OFS_LAST)
      data_ofs_nxt[lane*8 +: 8] = in_chan.file_byte;
    else if (pos >= WID_FIRST && pos <= WID_LAST)
      img_w_nxt[lane*8 +: 8] = in_chan.file_byte;
    else if (pos >= HGT_FIRST && pos <= HGT_LAST)
      img_h_nxt[lane*8 +: 8] = in_chan.file_byte;
    else if (pos == BPP_LO)
      bit_cnt_nxt[7:0] = in_chan.file_byte;
    else if (pos == BPP_HI)
      bit_cnt_nxt[15:8] = in_chan.file_byte;

    bpp = bit_cnt_nxt[14:3];
    // signed tests done as unsigned ranges: negatives look huge
    pixel = !data_ofs_nxt[31] && data_ofs_nxt >= MIN_OFS && pos >= data_ofs_nxt &&
            img_w_nxt != '0 && img_w_nxt <= 32'(MAX_DIM) &&
            img_h_nxt != '0 && img_h_nxt <= 32'(MAX_DIM) &&
            !bit_cnt_nxt[15] && bpp != '0 &&
            32'(row_c) < img_h_nxt;

    chan_inc = chan_c + 1'b1;
    col_inc  = col_c + 1'b1;
    chan_nxt = chan_c;
    col_nxt  = col_c;
    row_nxt  = row_c;
    if (pixel) begin
      if (chan_inc >= CNT_W'(bpp)) begin
        chan_nxt = '0;
        if (32'(col_inc) >= img_w_nxt) begin
          col_nxt = '0;
          row_nxt = row_c + 1'b1;
        end else begin
          col_nxt = col_inc;
        end
      end else begin
        chan_nxt = chan_inc;
      end
    end

    byte_pos_nxt = (pos == '1) ? pos : pos + 32'd1;

    // Operands for the address stage
    s1_valid_nxt = pixel && chan_c < CHAN_LIMIT;
    s1_byte_nxt  = in_chan.file_byte;
    s1_chan_nxt  = chan_c[1:0];
    s1_col_nxt   = col_c;
    sw_diff = $signed({2'b00, screen_width_r}) - $signed({2'b00, img_w_nxt[12:0]});
    if (center_mode_r)
      s1_left_nxt = 14'((sw_diff + $signed({14'd0, sw_diff[14]})) >>> 1);
    else
      s1_left_nxt = $signed({2'b00, left_column_r});
    s1_row_nxt = CNT_W'({1'b0, top_row_r} + img_h_nxt[12:0] - row_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      data_ofs_r <= '0;
      img_w_r    <= '0;
      img_h_r    <= '0;
      bit_cnt_r  <= '0;
      chan_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        byte_pos_r <= byte_pos_nxt;
        data_ofs_r <= data_ofs_nxt;
        img_w_r    <= img_w_nxt;
        img_h_r    <= img_h_nxt;
        bit_cnt_r  <= bit_cnt_nxt;
        chan_r     <= chan_nxt;
        col_r      <= col_nxt;
        row_r      <= row_nxt;
      end
      if (adv_s1)
        s1_valid_r <= in_acc && s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= s1_byte_nxt;
      s1_chan_r <= s1_chan_nxt;
      s1_col_r  <= s1_col_nxt;
      s1_left_r <= s1_left_nxt;
      s1_row_r  <= s1_row_nxt;
    end
  end

  // Address: 4 * (left + col + row * screen_width) + chan
  logic [25:0]        row_off;
  logic signed [30:0] pix_idx, addr;
  logic               addr_bad;

  always_comb begin
    row_off  = 26'(s1_row_r) * 26'(screen_width_r);
    pix_idx  = 31'(s1_left_r) + $signed({18'd0, s1_col_r}) + $signed({5'd0, row_off});
    addr     = (pix_idx <<< 2) + $signed({29'd0, s1_chan_r});
    addr_bad = addr[30] || addr > $signed(31'h7FF_FFFF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (adv_out)
      out_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_addr_r <= addr_bad ? '0 : addr[ADDR_W-1:0];
      out_byte_r <= s1_byte_r;
      out_off_r  <= addr_bad;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.write_address = out_addr_r;
  assign out_chan.write_byte    = out_byte_r;
  assign out_chan.off_frame     = out_off_r;

endmodule

[tb/bitmap_stream_blit_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench for bitmap_stream_blit_unit: bitmap byte streams checked against a write predictor.
module bitmap_stream_blit_unit_tb
  import bsb_pkg::*;
();

  localparam int     RANDOM_BYTES = 50;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 8;
  localparam longint ADDR_LIMIT   = (longint'(1) << ADDR_W) - 1;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [7:0]        data;
    logic              off_frame;
  } fb_write_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  bsb_in_if  in_if();
  bsb_out_if out_if();

  bitmap_stream_blit_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: placement registers and header parser
  logic [SW_W-1:0]  scr_width;
  logic             scr_center;
  logic [COL_W-1:0] scr_left;
  logic [COL_W-1:0] scr_top;
  logic [31:0]      fb_pos;
  logic [31:0]      hdr_data_ofs;
  logic [31:0]      hdr_width;
  logic [31:0]      hdr_height;
  logic [15:0]      hdr_bit_count;
  logic [CNT_W-1:0] pix_chan;
  logic [CNT_W-1:0] pix_col;
  logic [CNT_W-1:0] pix_row;

  fb_write_t expected_writes[$];

  int error_count    = 0;
  int bytes_taken    = 0;
  int writes_checked = 0;
  int off_frame_seen = 0;
  int files_sent     = 0;
  int cfg_writes     = 0;

  // Traffic shaping
  bit       tx_gaps       = 1'b1;
  rx_mode_t rx_mode       = RX_RANDOM;
  int       burst_left    = 0;
  int       hold_requests = 0;
  int       hold_served   = 0;

  function automatic void clear_parser();
    fb_pos        = '0;
    hdr_data_ofs  = '0;
    hdr_width     = '0;
    hdr_height    = '0;
    hdr_bit_count = '0;
    pix_chan      = '0;
    pix_col       = '0;
    pix_row       = '0;
  endfunction

  function automatic void predict_blit_write(input logic [7:0] b, input logic first);
    longint    ofs_v, wid_v, hgt_v, bytes_pp, left_v, row_v, addr_v;
    logic [31:0] pos;
    fb_write_t wr;
    if (first)
      clear_parser();
    pos = fb_pos;

    if (pos >= OFS_FIRST && pos <= OFS_LAST)
      hdr_data_ofs[8*(pos-OFS_FIRST) +: 8] = b;
    else if (pos >= WID_FIRST && pos <= WID_LAST)
      hdr_width[8*(pos-WID_FIRST) +: 8] = b;
    else if (pos >= HGT_FIRST && pos <= HGT_LAST)
      hdr_height[8*(pos-HGT_FIRST) +: 8] = b;
    else if (pos == BPP_LO)
      hdr_bit_count[7:0] = b;
    else if (pos == BPP_HI)
      hdr_bit_count[15:8] = b;

    ofs_v    = longint'($signed(hdr_data_ofs));
    wid_v    = longint'($signed(hdr_width));
    hgt_v    = longint'($signed(hdr_height));
    bytes_pp = longint'($signed(hdr_bit_count)) / 8;

    if (ofs_v >= longint'(MIN_OFS) && longint'(pos) >= ofs_v && wid_v > 0 && hgt_v > 0 &&
        bytes_pp > 0 && wid_v <= longint'(MAX_DIM) && hgt_v <= longint'(MAX_DIM) &&
        longint'(pix_row) < hgt_v) begin
      if (pix_chan < CHAN_LIMIT) begin
        left_v = scr_center ? (longint'(scr_width) - wid_v) / 2 : longint'(scr_left);
        // rows land bottom-up, from top_row + height up to top_row + 1
        row_v  = longint'(scr_top) + hgt_v - longint'(pix_row);
        addr_v = 4 * (left_v + longint'(pix_col) + row_v * longint'(scr_width)) +
                 longint'(pix_chan);
        wr.off_frame = (addr_v < 0) || (addr_v > ADDR_LIMIT);
        wr.address   = wr.off_frame ? '0 : addr_v[ADDR_W-1:0];
        wr.data      = b;
        expected_writes.push_back(wr);
      end
      pix_chan = pix_chan + 1'b1;
      if (longint'(pix_chan) >= bytes_pp) begin
        pix_chan = '0;
        pix_col  = pix_col + 1'b1;
        if (longint'(pix_col) >= wid_v) begin
          pix_col = '0;
          pix_row = pix_row + 1'b1;
        end
      end
    end

    if (fb_pos != '1)
      fb_pos = fb_pos + 1;
  endfunction

  // Scoreboard: results, accepted items and register writes, all at the rising edge
  always @(posedge clk) begin : scoreboard
    fb_write_t exp_w;
    if (!rst_n) begin
      scr_width  = SCREEN_WIDTH_RST;
      scr_center = CENTER_MODE_RST;
      scr_left   = LEFT_COLUMN_RST;
      scr_top    = TOP_ROW_RST;
      clear_parser();
      expected_writes.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_writes.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected write: expected none, got addr %h byte %h off_frame %b",
                   $time, out_if.write_address, out_if.write_byte, out_if.off_frame);
        end else begin
          exp_w = expected_writes.pop_front();
          writes_checked++;
          if (exp_w.off_frame)
            off_frame_seen++;
          if (out_if.write_address !== exp_w.address) begin
            error_count++;
            $display("%0t ns: write_address expected %h, got %h",
                     $time, exp_w.address, out_if.write_address);
          end
          if (out_if.write_byte !== exp_w.data) begin
            error_count++;
            $display("%0t ns: write_byte expected %h, got %h",
                     $time, exp_w.data, out_if.write_byte);
          end
          if (out_if.off_frame !== exp_w.off_frame) begin
            error_count++;
            $display("%0t ns: off_frame expected %b, got %b",
                     $time, exp_w.off_frame, out_if.off_frame);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        bytes_taken++;
        predict_blit_write(in_if.file_byte, in_if.first_byte);
      end
      if (cfg_we) begin
        cfg_writes++;
        case (cfg_index)
          CFG_SCREEN_WIDTH: scr_width  = cfg_data[SW_W-1:0];
          CFG_CENTER_MODE:  scr_center = cfg_data[0];
          CFG_LEFT_COLUMN:  scr_left   = cfg_data[COL_W-1:0];
          CFG_TOP_ROW:      scr_top    = cfg_data[COL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Output ready: mode-driven, with long hold-offs on request
  initial begin : rx_ready_gen
    int          held;
    logic [15:0] pat;
    out_if.ready = 1'b0;
    pat = 16'b1011_0110_1110_0101;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        out_if.ready <= 1'b0;
        held = 1;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_served++;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_if.ready <= 1'b1;
          RX_RANDOM: out_if.ready <= ($urandom_range(0, 99) < 65);
          default: begin
            out_if.ready <= pat[0];
            pat = {pat[0], pat[15:1]};
          end
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    if (burst_left == 0) begin
      gap = tx_gaps ? $urandom_range(1, 8) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_if.valid      <= 1'b0;
        in_if.file_byte  <= 8'($urandom);
        in_if.first_byte <= 1'($urandom);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.file_byte  <= b;
    in_if.first_byte <= first;
    @(posedge clk);
    while (!in_if.ready)
      @(posedge clk);
    burst_left--;
  endtask

  // Streams one file: header fields at their byte positions, everything else random.
  // noise_pm: chance per thousand of a stray new-file flag after byte 0.
  task automatic stream_file(input logic [31:0] ofs, input logic [31:0] wid,
                             input logic [31:0] hgt, input logic [15:0] bits,
                             input int total, input int noise_pm);
    logic [7:0] b;
    logic       first;
    files_sent++;
    for (int i = 0; i < total; i++) begin
      b = 8'($urandom);
      if (i >= OFS_FIRST && i <= OFS_LAST)
        b = ofs[8*(i-OFS_FIRST) +: 8];
      else if (i >= WID_FIRST && i <= WID_LAST)
        b = wid[8*(i-WID_FIRST) +: 8];
      else if (i >= HGT_FIRST && i <= HGT_LAST)
        b = hgt[8*(i-HGT_FIRST) +: 8];
      else if (i == BPP_LO)
        b = bits[7:0];
      else if (i == BPP_HI)
        b = bits[15:8];
      first = (i == 0) || (noise_pm != 0 && $urandom_range(0, 999) < noise_pm);
      send_byte(b, first);
    end
  endtask

  function automatic int pixel_file_len(input int ofs, input int wid, input int hgt,
                                        input int bits, input int trail);
    return ofs + wid * hgt * (bits / 8) + trail;
  endfunction

  // Drops valid, then waits out every expected write and any result-free item in flight
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_writes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_config(input logic [CFG_DAT_W-1:0] sw, input logic [CFG_DAT_W-1:0] center,
                            input logic [CFG_DAT_W-1:0] left, input logic [CFG_DAT_W-1:0] top);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_DAT_W-1:0] val [4];
    idx = '{CFG_SCREEN_WIDTH, CFG_CENTER_MODE, CFG_LEFT_COLUMN, CFG_TOP_ROW};
    val = '{sw, center, left, top};
    foreach (idx[k]) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Only with the input channel idle (after wait_idle)
  task automatic set_traffic(input bit gaps, input rx_mode_t mode);
    @(posedge clk);
    tx_gaps = gaps;
    rx_mode = mode;
  endtask

  task automatic test_reset_defaults();
    // registers untouched: centered on a 640 wide screen at row 0
    stream_file(54, 2, 2, 24, pixel_file_len(54, 2, 2, 24, 2), 0);
    wait_idle();
  endtask

  task automatic test_pixel_widths();
    set_config(13'd16, 13'd0, 13'd3, 13'd2);
    set_traffic(1'b0, RX_ALWAYS);
    stream_file(30, 3, 2, 8,  pixel_file_len(30, 3, 2, 8, 2), 0);
    stream_file(31, 2, 2, 16, pixel_file_len(31, 2, 2, 16, 0), 0);
    stream_file(30, 2, 1, 32, pixel_file_len(30, 2, 1, 32, 1), 0);
    stream_file(54, 1, 2, 40, pixel_file_len(54, 1, 2, 40, 0), 0);
    // bit counts that give no whole byte or a negative byte count
    stream_file(30, 2, 2, 7, 40, 0);
    stream_file(30, 1, 1, 16'h8008, 36, 0);
    // huge pixel: first three bytes only
    stream_file(30, 1, 1, 16'h7FFF, 40, 0);
    wait_idle();
  endtask

  task automatic test_bad_headers();
    set_config(13'd64, 13'd1, 13'd0, 13'd5);
    set_traffic(1'b1, RX_PATTERN);
    stream_file(29, 1, 1, 24, 40, 0);
    stream_file(32'h8000_0000, 1, 1, 24, 40, 0);
    stream_file(30, 1, 1, 24, 33, 0);
    stream_file(30, 0, 2, 24, 40, 0);
    stream_file(30, 32'hFFFF_FFFF, 2, 24, 40, 0);
    stream_file(30, 2, 0, 24, 40, 0);
    stream_file(30, 2, 32'h8000_0000, 24, 40, 0);
    stream_file(30, 4097, 1, 8, 40, 0);
    stream_file(30, 1, 4097, 8, 40, 0);
    stream_file(32'h7FFF_FFFF, 1, 1, 8, 40, 0);
    // largest sizes allowed, only a few pixels sent
    stream_file(30, 4096, 1, 8, 36, 0);
    stream_file(30, 1, 4096, 8, 34, 0);
    wait_idle();
  endtask

  task automatic test_off_frame_extremes();
    set_config(13'd8191, 13'd0, 13'd4095, 13'd4095);
    stream_file(30, 1, 4096, 24, 36, 0);
    wait_idle();
    set_config(13'd0, 13'd1, 13'd0, 13'd0);
    stream_file(30, 3, 2, 24, pixel_file_len(30, 3, 2, 24, 0), 0);
    wait_idle();
    set_config(13'd1, 13'd1, 13'd0, 13'd4095);
    stream_file(30, 5, 2, 24, pixel_file_len(30, 5, 2, 24, 0), 0);
    wait_idle();
  endtask

  task automatic test_restart_mid_file();
    set_config(13'd100, 13'd0, 13'd10, 13'd20);
    set_traffic(1'b1, RX_RANDOM);
    // cut off partway through a pixel, then a fresh file
    stream_file(30, 4, 3, 24, 40, 0);
    stream_file(32, 4, 3, 24, pixel_file_len(32, 4, 3, 24, 1), 0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_config(13'd320, 13'd1, 13'd0, 13'd7);
    set_traffic(1'b0, RX_ALWAYS);
    hold_requests++;
    stream_file(30, 8, 4, 24, pixel_file_len(30, 8, 4, 24, 0), 0);
    wait_idle();
  endtask

  task automatic test_random_files();
    int          start, kind, total, pick;
    logic [31:0] ofs, wid, hgt;
    logic [15:0] bits;
    logic [12:0] sw;
    logic [11:0] left, top;
    logic [15:0] bit_choices [9];
    logic [31:0] dim_edges [6];
    logic [31:0] ofs_edges [5];
    logic [15:0] bit_edges [6];
    bit_choices = '{16'd8, 16'd16, 16'd24, 16'd24, 16'd24, 16'd32, 16'd40, 16'd12, 16'd20};
    dim_edges   = '{32'd0, 32'd1, 32'd4096, 32'd4097, 32'hFFFF_FFFF, 32'h8000_0000};
    ofs_edges   = '{32'd29, 32'd30, 32'd31, 32'h8000_0000, 32'd0};
    bit_edges   = '{16'd0, 16'd7, 16'd8, 16'd24, 16'h8000, 16'hFFF8};
    start = bytes_taken;
    while (bytes_taken - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) begin
        wait_idle();
        pick = $urandom_range(0, 19);
        case (pick)
          0:       sw = 13'd1;
          1:       sw = 13'd8191;
          2:       sw = 13'd0;
          3:       sw = 13'd4096;
          default: sw = 13'($urandom_range(8, 1024));
        endcase
        left = ($urandom_range(0, 9) == 0) ? 12'd4095 : 12'($urandom_range(0, 300));
        top  = ($urandom_range(0, 9) == 0) ? 12'd4095 : 12'($urandom_range(0, 200));
        // unused high bits of the write data should be dropped
        set_config(sw, {12'($urandom), 1'($urandom)},
                   {1'($urandom_range(0, 7) == 0), left},
                   {1'($urandom_range(0, 7) == 0), top});
      end
      if ($urandom_range(0, 4) == 0) begin
        wait_idle();
        set_traffic($urandom_range(0, 3) != 0, rx_mode_t'($urandom_range(0, 2)));
      end
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        ofs   = ($urandom_range(0, 4) == 0) ? 32'd54 : 32'($urandom_range(30, 40));
        wid   = $urandom_range(1, 6);
        hgt   = $urandom_range(1, 4);
        bits  = bit_choices[$urandom_range(0, 8)];
        total = pixel_file_len(ofs, wid, hgt, bits, $urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
          total = $urandom_range(ofs, total);
        stream_file(ofs, wid, hgt, bits, total, (kind == 6) ? 15 : 0);
      end else if (kind == 7) begin
        stream_file($urandom, $urandom, $urandom, 16'($urandom), $urandom_range(30, 48), 0);
      end else if (kind == 8) begin
        stream_file(ofs_edges[$urandom_range(0, 4)], dim_edges[$urandom_range(0, 5)],
                    dim_edges[$urandom_range(0, 5)], bit_edges[$urandom_range(0, 5)],
                    30 + $urandom_range(0, 12), 0);
      end else begin
        stream_file(32'($urandom_range(0, 40)), $urandom_range(0, 8), $urandom_range(0, 8),
                    16'($urandom), $urandom_range(20, 60), 50);
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.file_byte  = '0;
    in_if.first_byte = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_SCREEN_WIDTH;
    cfg_data         = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_pixel_widths();
    test_bad_headers();
    test_off_frame_extremes();
    test_restart_mid_file();
    test_backpressure();
    test_random_files();
    wait_idle();

    $display("Streamed %0d file bytes in %0d files; %0d framebuffer writes checked, %0d off frame.",
             bytes_taken, files_sent, writes_checked, off_frame_seen);
    $display("Placement registers written %0d times; %0d long output hold-off(s).",
             cfg_writes, hold_served);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3ms;
    $display("%0t ns: timed out, %0d writes still expected", $time, expected_writes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
rtl/bsb_pkg.sv
rtl/bsb_in_if.sv
rtl/bsb_out_if.sv
rtl/bitmap_stream_blit_unit.sv
tb/bitmap_stream_blit_unit_tb.sv
